// ----- design/mbm_pkg.sv -----
// Package with the sizes, operation codes and result type of the message buffer manager.
package mbm_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int OP_W = 2;
   localparam int SLOT_W = 4;
   localparam int OFFSET_W = 16;
   localparam int COUNT_W = 5;
   localparam int SIZE_W = 13;
   localparam int PAD_W = SIZE_W + 1;

   localparam logic [SIZE_W-1:0] SLOT_BYTES_RESET = SIZE_W'(64);

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE = 2'd1;
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd2;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd3;

   typedef struct packed {
      logic ok;
      logic [SLOT_W-1:0] slot_out;
      logic [OFFSET_W-1:0] byte_offset;
      logic [COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0] queued_count;
   } rsp_type;

endpackage

// ----- design/mbm_if.sv -----
// Request and response channel interfaces of the message buffer manager.
interface mbm_req_if import mbm_pkg::*; ();
   logic valid;
   logic ready;
   logic [OP_W-1:0] op;
   logic [SLOT_W-1:0] slot_in;

   modport source (output valid, output op, output slot_in, input ready);
   modport sink (input valid, input op, input slot_in, output ready);
endinterface

interface mbm_rsp_if import mbm_pkg::*; ();
   logic valid;
   logic ready;
   logic ok;
   logic [SLOT_W-1:0] slot_out;
   logic [OFFSET_W-1:0] byte_offset;
   logic [COUNT_W-1:0] free_count;
   logic [COUNT_W-1:0] queued_count;

   modport source (output valid, output ok, output slot_out, output byte_offset,
                   output free_count, output queued_count, input ready);
   modport sink (input valid, input ok, input slot_out, input byte_offset,
                 input free_count, input queued_count, output ready);
endinterface

// ----- design/message_buffer_manager_core.sv -----
// Top level of the message buffer manager: free-slot ring, message ring and result buffer.

// The block takes one request per cycle and answers each with exactly one result,
// which goes to the output register, or to the skid register while that is full.
// All ring and counter updates are made on acceptance, so the sustained rate is
// one request per clock; only a stalled result side slows it, and the two-entry
// result buffer (output register plus skid register) lets one more request in
// while a result waits. The slot size register may be written only while the
// block is idle. No clearing pass is needed after reset.
module message_buffer_manager_core import mbm_pkg::*; (
   input  logic clock,
   input  logic reset,
   mbm_req_if.sink req_bus,
   mbm_rsp_if.source rsp_bus,
   input  logic csr_we,
   input  logic [SIZE_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0] slot_bytes_ff;
   logic [SLOT_W-1:0] free_ring_ff [DEPTH];
   logic [SLOT_W-1:0] message_ring_ff [DEPTH];
   logic [IDX_W-1:0] alloc_index_ff, alloc_index_in;
   logic [IDX_W-1:0] return_index_ff, return_index_in;
   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [CNT_W-1:0] free_slots_ff, free_slots_in;
   logic [CNT_W-1:0] queued_ff, queued_in;

   rsp_type out_ff, skid_ff, result;
   logic out_valid_ff, skid_valid_ff;

   logic accept, pop;
   logic free_we, msg_we;
   logic ok;
   logic [SLOT_W-1:0] result_slot;
   logic [PAD_W-1:0] padded;
   logic [SLOT_W+PAD_W-1:0] product;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

   assign req_bus.ready = !skid_valid_ff;
   assign accept = req_bus.valid && req_bus.ready;
   assign pop = out_valid_ff && rsp_bus.ready;

   always_comb begin
      ok = 1'b0;
      result_slot = '0;
      free_we = 1'b0;
      msg_we = 1'b0;
      alloc_index_in = alloc_index_ff;
      return_index_in = return_index_ff;
      read_index_in = read_index_ff;
      write_index_in = write_index_ff;
      free_slots_in = free_slots_ff;
      queued_in = queued_ff;
      case (req_bus.op)
         OP_ALLOC: begin
            if (free_slots_ff != '0) begin
               ok = 1'b1;
               result_slot = free_ring_ff[alloc_index_ff];
               alloc_index_in = ring_next(alloc_index_ff);
               free_slots_in = free_slots_ff - CNT_W'(1);
            end
         end
         OP_FREE: begin
            if (free_slots_ff != CNT_W'(DEPTH)) begin
               ok = 1'b1;
               result_slot = req_bus.slot_in;
               free_we = accept;
               return_index_in = ring_next(return_index_ff);
               free_slots_in = free_slots_ff + CNT_W'(1);
            end
         end
         OP_ENQUEUE: begin
            if (queued_ff != CNT_W'(DEPTH)) begin
               ok = 1'b1;
               result_slot = req_bus.slot_in;
               msg_we = accept;
               write_index_in = ring_next(write_index_ff);
               queued_in = queued_ff + CNT_W'(1);
            end
         end
         OP_DEQUEUE: begin
            if (queued_ff != '0) begin
               ok = 1'b1;
               result_slot = message_ring_ff[read_index_ff];
               read_index_in = ring_next(read_index_ff);
               queued_in = queued_ff - CNT_W'(1);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign padded = (PAD_W'(slot_bytes_ff) + PAD_W'(7)) & ~PAD_W'(7);
   assign product = (SLOT_W+PAD_W)'(result_slot) * (SLOT_W+PAD_W)'(padded);

   always_comb begin
      result.ok = ok;
      result.slot_out = result_slot;
      result.byte_offset = product[OFFSET_W-1:0];
      result.free_count = COUNT_W'(free_slots_in);
      result.queued_count = COUNT_W'(queued_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff <= SLOT_BYTES_RESET;
         alloc_index_ff <= '0;
         return_index_ff <= '0;
         read_index_ff <= '0;
         write_index_ff <= '0;
         free_slots_ff <= CNT_W'(DEPTH);
         queued_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            free_ring_ff[i] <= SLOT_W'(i);
         end
      end else begin
         if (csr_we) begin
            slot_bytes_ff <= csr_wdata;
         end
         if (accept) begin
            alloc_index_ff <= alloc_index_in;
            return_index_ff <= return_index_in;
            read_index_ff <= read_index_in;
            write_index_ff <= write_index_in;
            free_slots_ff <= free_slots_in;
            queued_ff <= queued_in;
         end
         if (free_we) begin
            free_ring_ff[return_index_ff] <= req_bus.slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (msg_we) begin
         message_ring_ff[write_index_ff] <= req_bus.slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.ok = out_ff.ok;
   assign rsp_bus.slot_out = out_ff.slot_out;
   assign rsp_bus.byte_offset = out_ff.byte_offset;
   assign rsp_bus.free_count = out_ff.free_count;
   assign rsp_bus.queued_count = out_ff.queued_count;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a result while the output register is empty.");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      free_slots_ff <= CNT_W'(DEPTH))
      else $error("Free slot count exceeds the pool size.");

   a_queued_in_range: assert property (@(posedge clock) disable iff (reset)
      queued_ff <= CNT_W'(DEPTH))
      else $error("Queued message count exceeds the ring size.");

   a_alloc_counts_down: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && req_bus.op == OP_ALLOC && free_slots_ff != '0)
      |=> free_slots_ff == $past(free_slots_ff) - CNT_W'(1))
      else $error("A successful allocation did not lower the free slot count.");

endmodule
